// ===== rtl/deadline_ordered_timer_queue_unit_macros.svh =====
// assertion macros used by the timer queue engine rtl
// expects clk_i and rst_ni in the scope of each use
`ifndef DEADLINE_ORDERED_TIMER_QUEUE_UNIT_MACROS_SVH
`define DEADLINE_ORDERED_TIMER_QUEUE_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define DOTQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define DOTQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/dotq_pkg.sv =====
// types and constants for the deadline ordered timer queue
// no dependencies
`default_nettype none

package dotq_pkg;

  localparam int ID_W   = 4;
  localparam int MODE_W = 3;
  localparam int TIME_W = 32;
  localparam int DL_W   = TIME_W + 1;
  localparam int CNT_W  = 5;

  typedef enum logic [MODE_W-1:0] {
    MODE_SCHEDULE = 3'd0,
    MODE_EXTEND   = 3'd1,
    MODE_CANCEL   = 3'd2,
    MODE_QUERY    = 3'd3,
    MODE_POP      = 3'd4,
    MODE_CLEAR    = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_HEAD,
    ST_CHECK,
    ST_DROP,
    ST_INSERT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [ID_W-1:0]   msg_id;
    logic [TIME_W-1:0] delay_ms;
    logic [TIME_W-1:0] now_ms;
  } in_t;

  typedef struct packed {
    logic             pop_valid;
    logic [ID_W-1:0]  popped_id;
    logic             is_pending;
    logic [CNT_W-1:0] queue_count;
  } out_t;

endpackage

`default_nettype wire

// ===== rtl/dotq_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module dotq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     wr_en_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]                         wr_data_i,
  input  wire logic                                     rd_en_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]                         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ===== rtl/dotq_engine.sv =====
// sequencer for the timer queue: order list and deadline rams, armed flags,
// drop and insert walks; depends on dotq_pkg, dotq_ram and the macro header
`default_nettype none
`include "deadline_ordered_timer_queue_unit_macros.svh"

module dotq_engine
  import dotq_pkg::*;
#(
  parameter int NUM_MSGS = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_data_i,
  output logic      res_valid_o,
  input  wire logic res_ready_i,
  output out_t      res_o
);

  localparam int IdxW = (NUM_MSGS > 1) ? $clog2(NUM_MSGS) : 1;
  localparam int LenW = $clog2(NUM_MSGS + 1);

  state_e state_q, state_d;

  in_t              cmd_q, cmd_d;
  logic [DL_W-1:0]  new_dl_q, new_dl_d;
  logic [ID_W-1:0]  tgt_id_q, tgt_id_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [NUM_MSGS-1:0] armed_q, armed_d;
  logic [LenW-1:0]  rp_q, rp_d;
  logic             v1_q, v1_d;
  logic             v2_q, v2_d;
  logic [IdxW-1:0]  k1_q, k1_d;
  logic [IdxW-1:0]  k2_q, k2_d;
  logic [ID_W-1:0]  e2_q, e2_d;
  logic [ID_W-1:0]  carry_q, carry_d;
  logic             found_q, found_d;
  logic             ins_q, ins_d;
  logic             place_q, place_d;
  logic             pend_q, pend_d;
  logic             pop_valid_q, pop_valid_d;
  logic [ID_W-1:0]  popped_q, popped_d;
  logic             pending_q, pending_d;

  // ram ports
  logic            ord_wr_en, ord_rd_en;
  logic [IdxW-1:0] ord_wr_addr, ord_rd_addr;
  logic [ID_W-1:0] ord_wr_data, ord_rdata;
  logic            dl_wr_en, dl_rd_en;
  logic [IdxW-1:0] dl_wr_addr, dl_rd_addr;
  logic [DL_W-1:0] dl_wr_data, dl_rdata;

  mode_e           cmd_mode;
  logic            id_ok;
  logic [IdxW-1:0] tgt_idx;
  logic [DL_W-1:0] now_ext;
  logic            pop_due;
  logic            place_go;
  logic            scan_rd;
  logic            walk_idle;
  logic            drop_hit;
  logic [LenW-1:0] len_after;

  dotq_ram #(
    .WIDTH(ID_W),
    .DEPTH(NUM_MSGS)
  ) u_order_ram (
    .clk_i    (clk_i),
    .wr_en_i  (ord_wr_en),
    .wr_addr_i(ord_wr_addr),
    .wr_data_i(ord_wr_data),
    .rd_en_i  (ord_rd_en),
    .rd_addr_i(ord_rd_addr),
    .rd_data_o(ord_rdata)
  );

  // deadlines are only used for armed or listed ids, all written before
  dotq_ram #(
    .WIDTH(DL_W),
    .DEPTH(NUM_MSGS)
  ) u_deadline_ram (
    .clk_i    (clk_i),
    .wr_en_i  (dl_wr_en),
    .wr_addr_i(dl_wr_addr),
    .wr_data_i(dl_wr_data),
    .rd_en_i  (dl_rd_en),
    .rd_addr_i(dl_rd_addr),
    .rd_data_o(dl_rdata)
  );

  assign cmd_mode  = mode_e'(cmd_q.mode);
  assign id_ok     = (32'(cmd_q.msg_id) < 32'(NUM_MSGS));
  assign tgt_idx   = IdxW'(tgt_id_q);
  assign now_ext   = {1'b0, cmd_q.now_ms};
  assign pop_due   = armed_q[tgt_idx] && (now_ext >= dl_rdata);
  assign place_go  = (cmd_mode == MODE_SCHEDULE) ||
                     ((cmd_mode == MODE_EXTEND) &&
                      (!armed_q[tgt_idx] || (new_dl_q > dl_rdata)));
  assign scan_rd   = (rp_q < len_q);
  assign walk_idle = !scan_rd && !v1_q && !v2_q;
  // a query walks the list without removing anything
  assign drop_hit  = found_q && (cmd_mode != MODE_QUERY);
  assign len_after = drop_hit ? (len_q - LenW'(1)) : len_q;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);
  assign res_o       = '{pop_valid:   pop_valid_q,
                         popped_id:   popped_q,
                         is_pending:  pending_q,
                         queue_count: CNT_W'(len_q)};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_FETCH;
      end
      ST_FETCH: begin
        unique case (cmd_mode)
          MODE_CLEAR:    state_d = ST_DONE;
          MODE_POP:      state_d = (len_q != '0) ? ST_HEAD : ST_DONE;
          MODE_SCHEDULE,
          MODE_EXTEND,
          MODE_CANCEL,
          MODE_QUERY:    state_d = id_ok ? ST_CHECK : ST_DONE;
          default:       state_d = ST_DONE;
        endcase
      end
      ST_HEAD: state_d = ST_CHECK;
      ST_CHECK: begin
        unique case (cmd_mode)
          MODE_POP:      state_d = pop_due ? ST_DROP : ST_DONE;
          MODE_SCHEDULE,
          MODE_EXTEND:   state_d = place_go ? ST_DROP : ST_DONE;
          MODE_CANCEL,
          MODE_QUERY:    state_d = ST_DROP;
          default:       state_d = ST_DONE;
        endcase
      end
      ST_DROP: begin
        if (walk_idle) begin
          state_d = (place_q && (len_after < LenW'(NUM_MSGS))) ? ST_INSERT : ST_DONE;
        end
      end
      ST_INSERT: begin
        if (walk_idle) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (res_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and ram control
  always_comb begin
    cmd_d       = cmd_q;
    new_dl_d    = new_dl_q;
    tgt_id_d    = tgt_id_q;
    len_d       = len_q;
    armed_d     = armed_q;
    rp_d        = rp_q;
    v1_d        = v1_q;
    v2_d        = v2_q;
    k1_d        = k1_q;
    k2_d        = k2_q;
    e2_d        = e2_q;
    carry_d     = carry_q;
    found_d     = found_q;
    ins_d       = ins_q;
    place_d     = place_q;
    pend_d      = pend_q;
    pop_valid_d = pop_valid_q;
    popped_d    = popped_q;
    pending_d   = pending_q;

    ord_wr_en   = 1'b0;
    ord_wr_addr = '0;
    ord_wr_data = '0;
    ord_rd_en   = 1'b0;
    ord_rd_addr = '0;
    dl_wr_en    = 1'b0;
    dl_wr_addr  = tgt_idx;
    dl_wr_data  = new_dl_q;
    dl_rd_en    = 1'b0;
    dl_rd_addr  = tgt_idx;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d       = in_data_i;
          new_dl_d    = {1'b0, in_data_i.delay_ms} + {1'b0, in_data_i.now_ms};
          tgt_id_d    = in_data_i.msg_id;
          place_d     = 1'b0;
          pend_d      = 1'b0;
          pop_valid_d = 1'b0;
          popped_d    = '0;
          pending_d   = 1'b0;
        end
      end
      ST_FETCH: begin
        unique case (cmd_mode)
          MODE_CLEAR: len_d = '0;
          MODE_POP: begin
            ord_rd_en   = (len_q != '0);
            ord_rd_addr = '0;
          end
          MODE_SCHEDULE,
          MODE_EXTEND,
          MODE_CANCEL,
          MODE_QUERY: dl_rd_en = id_ok;
          default: ;
        endcase
      end
      ST_HEAD: begin
        tgt_id_d   = ord_rdata;
        dl_rd_en   = 1'b1;
        dl_rd_addr = IdxW'(ord_rdata);
      end
      ST_CHECK: begin
        rp_d    = '0;
        v1_d    = 1'b0;
        v2_d    = 1'b0;
        found_d = 1'b0;
        ins_d   = 1'b0;
        unique case (cmd_mode)
          MODE_POP: begin
            if (pop_due) begin
              armed_d[tgt_idx] = 1'b0;
              pop_valid_d      = 1'b1;
              popped_d         = tgt_id_q;
            end
          end
          MODE_SCHEDULE,
          MODE_EXTEND: begin
            if (place_go) begin
              dl_wr_en         = 1'b1;
              armed_d[tgt_idx] = 1'b1;
              place_d          = 1'b1;
            end
          end
          MODE_QUERY: pend_d = armed_q[tgt_idx] && (now_ext < dl_rdata);
          default: ;
        endcase
      end
      ST_DROP: begin
        v1_d = scan_rd;
        if (scan_rd) begin
          ord_rd_en   = 1'b1;
          ord_rd_addr = IdxW'(rp_q);
          rp_d        = rp_q + LenW'(1);
          k1_d        = IdxW'(rp_q);
        end
        if (v1_q) begin
          // entries behind the removed one move up by one place
          if (drop_hit) begin
            ord_wr_en   = 1'b1;
            ord_wr_addr = k1_q - IdxW'(1);
            ord_wr_data = ord_rdata;
          end
          if (ord_rdata == tgt_id_q) found_d = 1'b1;
        end
        if (walk_idle) begin
          len_d = len_after;
          rp_d  = '0;
          if ((cmd_mode == MODE_CANCEL) && found_q) armed_d[tgt_idx] = 1'b0;
          if (cmd_mode == MODE_QUERY) pending_d = found_q && pend_q;
        end
      end
      ST_INSERT: begin
        v1_d = scan_rd;
        if (scan_rd) begin
          ord_rd_en   = 1'b1;
          ord_rd_addr = IdxW'(rp_q);
          rp_d        = rp_q + LenW'(1);
          k1_d        = IdxW'(rp_q);
        end
        v2_d = v1_q;
        if (v1_q) begin
          dl_rd_en   = 1'b1;
          dl_rd_addr = IdxW'(ord_rdata);
          e2_d       = ord_rdata;
          k2_d       = k1_q;
        end
        if (v2_q) begin
          // new id lands before the first entry that is not earlier
          if (ins_q) begin
            ord_wr_en   = 1'b1;
            ord_wr_addr = k2_q;
            ord_wr_data = carry_q;
            carry_d     = e2_q;
          end else if (dl_rdata >= new_dl_q) begin
            ord_wr_en   = 1'b1;
            ord_wr_addr = k2_q;
            ord_wr_data = tgt_id_q;
            carry_d     = e2_q;
            ins_d       = 1'b1;
          end
        end
        if (walk_idle) begin
          ord_wr_en   = 1'b1;
          ord_wr_addr = IdxW'(len_q);
          ord_wr_data = ins_q ? carry_q : tgt_id_q;
          len_d       = len_q + LenW'(1);
        end
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      len_q   <= '0;
      armed_q <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      found_q <= 1'b0;
      ins_q   <= 1'b0;
      place_q <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      armed_q <= armed_d;
      v1_q    <= v1_d;
      v2_q    <= v2_d;
      found_q <= found_d;
      ins_q   <= ins_d;
      place_q <= place_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    new_dl_q    <= new_dl_d;
    tgt_id_q    <= tgt_id_d;
    rp_q        <= rp_d;
    k1_q        <= k1_d;
    k2_q        <= k2_d;
    e2_q        <= e2_d;
    carry_q     <= carry_d;
    pend_q      <= pend_d;
    pop_valid_q <= pop_valid_d;
    popped_q    <= popped_d;
    pending_q   <= pending_d;
  end

  `DOTQ_ASSERT_IMP(a_idle_walk_empty, state_q == ST_IDLE, !v1_q && !v2_q, "walk pipeline busy while idle")
  `DOTQ_ASSERT_NXT(a_insert_has_room, (state_q == ST_DROP) && (state_d == ST_INSERT), len_q < LenW'(NUM_MSGS), "insert started on a full list")
  `DOTQ_ASSERT_NXT(a_pop_disarms, (state_q == ST_CHECK) && (cmd_mode == MODE_POP) && pop_due, !armed_q[$past(tgt_idx)] && pop_valid_q, "popped id still armed")
  `DOTQ_ASSERT_NXT(a_done_holds, (state_q == ST_DONE) && !res_ready_i, (state_q == ST_DONE) && $stable(len_q), "result word changed while stalled")

endmodule

`default_nettype wire

// ===== rtl/deadline_ordered_timer_queue_unit.sv =====
// deadline_ordered_timer_queue_unit: engine plus output register
// depends on dotq_pkg and dotq_engine
//
// Timer queue that keeps up to NUM_MSGS ids in deadline order.
// Input channel (in_valid_i/in_ready_o/in_data_i) carries one command word:
// mode, msg_id, delay_ms, now_ms. Output channel (out_valid_o/out_ready_i/
// out_data_o) returns exactly one result word per command, in order.
// Commands are handled one at a time; in_ready_o is high while the engine
// is idle, also while a finished result still sits in the output register.
// The list walks set how long a command takes: the drop walk reads the
// order ram once per entry, the insert walk reads order ram then deadline
// ram per entry, each ram having one read port with a registered read.
// Reset empties the list and clears every armed flag; no clearing pass.
// If the receiver stalls, the result word is held in the output register,
// the engine takes the next command and parks its result until the
// register frees up.
`default_nettype none

module deadline_ordered_timer_queue_unit
  import dotq_pkg::*;
#(
  parameter int NUM_MSGS = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_data_o
);

  logic res_valid;
  logic res_ready;
  out_t res;

  logic out_valid_q, out_valid_d;
  out_t out_data_q, out_data_d;

  dotq_engine #(
    .NUM_MSGS(NUM_MSGS)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_data_d  = res;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// ===== tb/sv/deadline_ordered_timer_queue_unit_tb.sv =====
// self-checking bench for deadline_ordered_timer_queue_unit: directed table then random commands
// depends on dotq_pkg and the unit rtl; answers come from a model of the deadline ordered list or typed table rows
`timescale 1ns / 1ps

module deadline_ordered_timer_queue_unit_tb;
  import dotq_pkg::*;

  localparam int NUM_IDS     = 16;
  localparam int RAND_CMDS   = 1825;
  localparam int CALM_CMDS   = 150;
  localparam int DRAIN_WAIT  = 60;
  localparam int QUIET_LIMIT = 4000;

  // modes with no operation behind them
  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

  typedef struct packed {
    in_t  cmd;
    bit   fixed;
    out_t res;
  } plan_row_t;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  in_t  in_data   = '0;
  logic out_ready = 1'b0;
  bit   row_fixed = 1'b0;
  out_t row_res   = '0;
  logic in_ready;
  logic out_valid;
  out_t out_data;

  bit calm = 1'b0;
  int fail_cnt = 0;
  int quiet_cycles = 0;

  // model state: ids in deadline order, per-id deadline and armed flag
  bit [ID_W-1:0] deadline_order[$];
  bit [DL_W-1:0] due_at[NUM_IDS];
  bit            armed[NUM_IDS];
  out_t          queue_answers[$];
  plan_row_t     plan_q[$];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  deadline_ordered_timer_queue_unit #(.NUM_MSGS(NUM_IDS)) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  function automatic int find_listed(bit [ID_W-1:0] id);
    foreach (deadline_order[i]) begin
      if (deadline_order[i] == id) return i;
    end
    return -1;
  endfunction

  // new entry goes in front of any entry with an equal deadline
  function automatic void requeue(bit [ID_W-1:0] id, bit [DL_W-1:0] when);
    int pos;
    pos = find_listed(id);
    if (pos >= 0) deadline_order.delete(pos);
    due_at[id] = when;
    armed[id]  = 1'b1;
    pos = 0;
    while (pos < deadline_order.size() && due_at[deadline_order[pos]] < when) pos++;
    deadline_order.insert(pos, id);
  endfunction

  function automatic out_t timer_queue_step(in_t cmd);
    out_t            res;
    bit [DL_W-1:0]   when;
    bit [DL_W-1:0]   now;
    bit [ID_W-1:0]   id;
    bit [ID_W-1:0]   head;
    int              pos;
    res  = '0;
    id   = cmd.msg_id;
    now  = DL_W'(cmd.now_ms);
    when = DL_W'(cmd.delay_ms) + now;
    case (cmd.mode)
      MODE_SCHEDULE: requeue(id, when);
      MODE_EXTEND: begin
        if (!armed[id] || when > due_at[id]) requeue(id, when);
      end
      MODE_CANCEL: begin
        pos = find_listed(id);
        if (pos >= 0) begin
          armed[id] = 1'b0;
          deadline_order.delete(pos);
        end
      end
      MODE_QUERY: begin
        res.is_pending = (find_listed(id) >= 0) && armed[id] && (now < due_at[id]);
      end
      MODE_POP: begin
        if (deadline_order.size() > 0) begin
          head = deadline_order[0];
          if (armed[head] && now >= due_at[head]) begin
            armed[head] = 1'b0;
            void'(deadline_order.pop_front());
            res.pop_valid = 1'b1;
            res.popped_id = head;
          end
        end
      end
      MODE_CLEAR: deadline_order.delete();
      default: ;
    endcase
    res.queue_count = CNT_W'(deadline_order.size());
    return res;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_cnt++;
    end
  endfunction

  // predict on each accepted command word, check each accepted result word
  always @(posedge clk) begin
    out_t want;
    bit   moved;
    moved = 1'b0;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        moved = 1'b1;
        want  = timer_queue_step(in_data);
        if (row_fixed) want = row_res;
        queue_answers.push_back(want);
      end
      if (out_valid && out_ready) begin
        moved = 1'b1;
        if (queue_answers.size() == 0) begin
          $display("%0t ns: result word with nothing outstanding, popped_id %0d count %0d",
                   $time, out_data.popped_id, out_data.queue_count);
          fail_cnt++;
        end else begin
          want = queue_answers.pop_front();
          check_field("pop_valid", 8'(want.pop_valid), 8'(out_data.pop_valid));
          check_field("popped_id", 8'(want.popped_id), 8'(out_data.popped_id));
          check_field("is_pending", 8'(want.is_pending), 8'(out_data.is_pending));
          check_field("queue_count", 8'(want.queue_count), 8'(out_data.queue_count));
        end
      end
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t ns: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  // receiver stalls in short bursts
  initial begin : receiver
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  task automatic add_row(logic [MODE_W-1:0] mode, logic [ID_W-1:0] id,
                         logic [TIME_W-1:0] delay, logic [TIME_W-1:0] now,
                         bit fixed, out_t res);
    plan_row_t row;
    row.cmd   = '{mode: mode, msg_id: id, delay_ms: delay, now_ms: now};
    row.fixed = fixed;
    row.res   = res;
    plan_q.push_back(row);
  endtask

  // valid stays up between back-to-back words, dropped only for a gap
  task automatic issue_cmd(in_t cmd, bit fixed, out_t res);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_data   <= cmd;
    row_fixed <= fixed;
    row_res   <= res;
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin : stimulus
    in_t             cmd;
    int              n_live;
    int              pick;
    bit [TIME_W-1:0] clock_ms;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // mode id delay now, then a typed answer where it is obvious
    add_row(MODE_QUERY,    4'd0,  32'd0,          32'd0,          1, {1'b0, 4'd0, 1'b0, 5'd0});
    add_row(MODE_POP,      4'd0,  32'd0,          32'd0,          1, {1'b0, 4'd0, 1'b0, 5'd0});
    add_row(MODE_SPARE_LO, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, {1'b0, 4'd0, 1'b0, 5'd0});
    add_row(MODE_SPARE_HI, 4'd0,  32'd0,          32'd0,          1, {1'b0, 4'd0, 1'b0, 5'd0});
    add_row(MODE_CANCEL,   4'd3,  32'd0,          32'd0,          1, {1'b0, 4'd0, 1'b0, 5'd0});
    // largest deadline needs the carry bit
    add_row(MODE_SCHEDULE, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, {1'b0, 4'd0, 1'b0, 5'd1});
    add_row(MODE_QUERY,    4'd15, 32'd0,          32'hFFFF_FFFF, 1, {1'b0, 4'd0, 1'b1, 5'd1});
    add_row(MODE_POP,      4'd0,  32'd0,          32'hFFFF_FFFF, 1, {1'b0, 4'd0, 1'b0, 5'd1});
    // equal deadlines: the later insert comes out first
    add_row(MODE_SCHEDULE, 4'd1,  32'd5,          32'd10,         1, {1'b0, 4'd0, 1'b0, 5'd2});
    add_row(MODE_SCHEDULE, 4'd2,  32'd0,          32'd15,         1, {1'b0, 4'd0, 1'b0, 5'd3});
    add_row(MODE_POP,      4'd0,  32'd0,          32'd15,         1, {1'b1, 4'd2, 1'b0, 5'd2});
    add_row(MODE_POP,      4'd0,  32'd0,          32'd15,         1, {1'b1, 4'd1, 1'b0, 5'd1});
    add_row(MODE_EXTEND,   4'd15, 32'd0,          32'd0,          0, '0);
    add_row(MODE_EXTEND,   4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, '0);
    add_row(MODE_EXTEND,   4'd4,  32'd100,        32'd0,          0, '0);
    add_row(MODE_EXTEND,   4'd4,  32'd200,        32'd0,          0, '0);
    // clear keeps the flags, so id 4 stays armed while unlisted
    add_row(MODE_CLEAR,    4'd0,  32'd0,          32'd0,          1, {1'b0, 4'd0, 1'b0, 5'd0});
    add_row(MODE_QUERY,    4'd4,  32'd0,          32'd0,          1, {1'b0, 4'd0, 1'b0, 5'd0});
    add_row(MODE_EXTEND,   4'd4,  32'd50,         32'd0,          1, {1'b0, 4'd0, 1'b0, 5'd0});
    add_row(MODE_EXTEND,   4'd4,  32'd300,        32'd0,          1, {1'b0, 4'd0, 1'b0, 5'd1});
    add_row(MODE_QUERY,    4'd4,  32'd0,          32'd300,        1, {1'b0, 4'd0, 1'b0, 5'd1});
    add_row(MODE_CANCEL,   4'd4,  32'd0,          32'd0,          1, {1'b0, 4'd0, 1'b0, 5'd0});
    add_row(MODE_CANCEL,   4'd0,  32'd0,          32'd0,          0, '0);
    add_row(MODE_SCHEDULE, 4'd0,  32'd0,          32'd0,          1, {1'b0, 4'd0, 1'b0, 5'd1});
    add_row(MODE_POP,      4'd0,  32'd0,          32'd0,          1, {1'b1, 4'd0, 1'b0, 5'd0});

    foreach (plan_q[i]) issue_cmd(plan_q[i].cmd, plan_q[i].fixed, plan_q[i].res);

    // random part: time mostly creeps forward so deadlines fall due
    clock_ms = $urandom_range(0, 1000);
    n_live   = 0;
    while (n_live < RAND_CMDS) begin
      calm = (n_live >= RAND_CMDS - CALM_CMDS);
      if (n_live == 600) clock_ms = 32'hFFFF_FE00;
      pick = $urandom_range(0, 99);
      if (pick < 30)      cmd.mode = MODE_SCHEDULE;
      else if (pick < 50) cmd.mode = MODE_EXTEND;
      else if (pick < 62) cmd.mode = MODE_CANCEL;
      else if (pick < 76) cmd.mode = MODE_QUERY;
      else if (pick < 96) cmd.mode = MODE_POP;
      else if (pick < 97) cmd.mode = MODE_CLEAR;
      else                cmd.mode = $urandom_range(0, 1) ? MODE_SPARE_HI : MODE_SPARE_LO;
      cmd.msg_id = ID_W'($urandom_range(0, NUM_IDS - 1));
      pick = $urandom_range(0, 99);
      if (pick < 15)      cmd.delay_ms = $urandom;
      else if (pick < 25) cmd.delay_ms = '0;
      else                cmd.delay_ms = $urandom_range(1, 40);
      clock_ms += $urandom_range(0, 6);
      cmd.now_ms = ($urandom_range(0, 99) < 15) ? TIME_W'($urandom) : clock_ms;
      issue_cmd(cmd, 1'b0, '0);
      if (cmd.mode != MODE_SPARE_LO && cmd.mode != MODE_SPARE_HI) n_live++;
    end
    in_valid <= 1'b0;

    while (queue_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (queue_answers.size() != 0) begin
      $display("%0t ns: result words missing, expected %0d more, actual 0",
               $time, queue_answers.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
